[src/scs_pkg.sv]
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and constants for the stack calculator: instruction and status
// codes, fixed-point limits, and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package scs_pkg;

  localparam int STACK_DEPTH_DEF = 256;
  localparam int DATA_W          = 32;
  localparam int FRAC_W          = 16;
  localparam int DEPTH_W         = 9;
  localparam int DIV_BITS        = DATA_W + FRAC_W;
  localparam int DIV_CNT_W       = $clog2(DIV_BITS);

  localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_NEG  = 3'd1,
    OP_ADD  = 3'd2,
    OP_SUB  = 3'd3,
    OP_MUL  = 3'd4,
    OP_DIV  = 3'd5,
    OP_RET  = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_FULL  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    op_t     op;
    status_t status;
    logic    fin;
    logic    load_in;
    logic    do_push;
    logic    do_neg;
    logic    do_ret;
    logic    lat_first;
    logic    exec;
    logic    mul_fin;
    logic    div_step;
    logic    div_fin;
    logic    wb;
    logic    out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic count_zero;
    logic count_lt2;
    logic count_full;
    logic top_zero;
    logic div_last;
  } dp_sts_t;

endpackage

[src/scs_ram.sv]
// ----------------------------------------------------------------------------
// scs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

[src/scs_ctrl.sv]
// ----------------------------------------------------------------------------
// scs_ctrl
// Instruction sequencer: decodes one instruction, checks stack bounds and
// steps the datapath through read, execute, write-back and result transfer.
// ----------------------------------------------------------------------------
module scs_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             in_func,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  scs_pkg::dp_sts_t       sts,
  output scs_pkg::cmd_t          cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_READ   = 9'b000000100,
    S_EXEC   = 9'b000001000,
    S_MUL    = 9'b000010000,
    S_DIV    = 9'b000100000,
    S_DIVFIN = 9'b001000000,
    S_WB     = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t                state_r, state_nxt;
  scs_pkg::op_t          op_r, op_nxt;
  scs_pkg::status_t      st_r, st_nxt;
  logic                  fin_r, fin_nxt;
  logic                  out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    st_nxt      = st_r;
    fin_nxt     = fin_r;
    cmd         = '0;
    cmd.op      = op_r;
    cmd.status  = st_r;
    cmd.fin     = fin_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          op_nxt      = scs_pkg::op_t'(in_func);
          st_nxt      = scs_pkg::ST_OK;
          fin_nxt     = 1'b0;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        case (op_r)
          scs_pkg::OP_PUSH: begin
            if (sts.count_full) st_nxt = scs_pkg::ST_FULL;
            else cmd.do_push = 1'b1;
          end
          scs_pkg::OP_NEG: begin
            if (sts.count_zero) st_nxt = scs_pkg::ST_UNDER;
            else cmd.do_neg = 1'b1;
          end
          scs_pkg::OP_ADD, scs_pkg::OP_SUB, scs_pkg::OP_MUL, scs_pkg::OP_DIV: begin
            if (sts.count_lt2) begin
              st_nxt = scs_pkg::ST_UNDER;
            end else if (op_r == scs_pkg::OP_DIV && sts.top_zero) begin
              st_nxt = scs_pkg::ST_DIVZ;
            end else begin
              // ram is addressed at the entry below the top, data lands next cycle
              state_nxt = S_READ;
            end
          end
          scs_pkg::OP_RET: begin
            if (sts.count_zero) begin
              st_nxt = scs_pkg::ST_UNDER;
            end else begin
              cmd.do_ret = 1'b1;
              fin_nxt    = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_READ: begin
        cmd.lat_first = 1'b1;
        state_nxt     = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (op_r)
          scs_pkg::OP_MUL: state_nxt = S_MUL;
          scs_pkg::OP_DIV: state_nxt = S_DIV;
          default:         state_nxt = S_WB;
        endcase
      end
      S_MUL: begin
        cmd.mul_fin = 1'b1;
        state_nxt   = S_WB;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_DIVFIN;
      end
      S_DIVFIN: begin
        cmd.div_fin = 1'b1;
        state_nxt   = S_WB;
      end
      S_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= scs_pkg::OP_PUSH;
      st_r        <= scs_pkg::ST_OK;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      st_r        <= st_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[src/scs_dpath.sv]
// ----------------------------------------------------------------------------
// scs_dpath
// Stack datapath: operand stack ram with a cached top entry, stack counter,
// saturating add/sub, registered multiplier, restoring divider and the
// result register.
// ----------------------------------------------------------------------------
module scs_dpath #(
  parameter int STACK_DEPTH = scs_pkg::STACK_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [scs_pkg::DATA_W-1:0]   in_operand,
  input  scs_pkg::cmd_t                       cmd,
  output scs_pkg::dp_sts_t                    sts,
  output logic [1:0]                          out_status,
  output logic signed [scs_pkg::DATA_W-1:0]   out_top_value,
  output logic [scs_pkg::DEPTH_W-1:0]         out_depth,
  output logic                                out_finished
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int DW = scs_pkg::DATA_W;
  localparam int FW = scs_pkg::FRAC_W;
  localparam int QW = scs_pkg::DIV_BITS;

  logic [CW-1:0]          count_r, count_nxt;
  logic signed [DW-1:0]   top_r, top_nxt;
  logic signed [DW-1:0]   opnd_r;
  logic signed [DW-1:0]   a_r;
  logic signed [DW-1:0]   res_r;
  logic signed [2*DW-1:0] p_r;
  logic [QW-1:0]          dq_r;
  logic [DW-1:0]          rem_r;
  logic [DW-1:0]          ub_r;
  logic                   neg_r;
  logic [scs_pkg::DIV_CNT_W-1:0] cnt_r;

  logic [1:0]             ost_r;
  logic signed [DW-1:0]   otop_r;
  logic [scs_pkg::DEPTH_W-1:0] odepth_r;
  logic                   ofin_r;

  logic [CW-1:0]          cnt_m1, cnt_m2;
  logic signed [DW-1:0]   neg_val;
  logic signed [DW:0]     sum;
  logic signed [DW-1:0]   sum_sat;
  logic [DW-1:0]          ua, ub;
  logic [DW:0]            rem_sh;
  logic                   rem_ge;
  logic [DW:0]            rem_sub;
  logic signed [DW-1:0]   mul_sat;
  logic [2*DW-1:FW+DW-1]  p_hi;
  logic signed [DW-1:0]   div_sat;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [DW-1:0]          ram_wdata;
  logic [DW-1:0]          ram_rdata;

  assign cnt_m1 = count_r - CW'(1);
  assign cnt_m2 = count_r - CW'(2);

  // negation saturates only at the most negative value
  assign neg_val = (top_r == scs_pkg::Q_MIN) ? scs_pkg::Q_MAX : -top_r;

  always_comb begin
    if (cmd.op == scs_pkg::OP_SUB) sum = (DW+1)'(a_r) - (DW+1)'(top_r);
    else sum = (DW+1)'(a_r) + (DW+1)'(top_r);
    if (sum[DW] != sum[DW-1]) sum_sat = sum[DW] ? scs_pkg::Q_MIN : scs_pkg::Q_MAX;
    else sum_sat = sum[DW-1:0];
  end

  assign ua = a_r[DW-1] ? (~a_r + DW'(1)) : a_r;
  assign ub = top_r[DW-1] ? (~top_r + DW'(1)) : top_r;

  // one quotient bit per cycle
  assign rem_sh  = {rem_r, dq_r[QW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, ub_r});
  assign rem_sub = rem_sh - {1'b0, ub_r};

  // arithmetic shift of the product floors toward minus infinity
  assign p_hi = p_r[2*DW-1:FW+DW-1];
  always_comb begin
    if ((&p_hi) || !(|p_hi)) mul_sat = p_r[FW+DW-1:FW];
    else mul_sat = p_r[2*DW-1] ? scs_pkg::Q_MIN : scs_pkg::Q_MAX;
  end

  always_comb begin
    if (neg_r) begin
      if (dq_r > QW'({1'b1, {(DW-1){1'b0}}})) div_sat = scs_pkg::Q_MIN;
      else div_sat = -(dq_r[DW-1:0]);
    end else begin
      if (dq_r > QW'(scs_pkg::Q_MAX)) div_sat = scs_pkg::Q_MAX;
      else div_sat = dq_r[DW-1:0];
    end
  end

  always_comb begin
    count_nxt = count_r;
    top_nxt   = top_r;
    ram_we    = 1'b0;
    ram_waddr = count_r[AW-1:0];
    ram_wdata = opnd_r;
    if (cmd.do_push) begin
      count_nxt = count_r + CW'(1);
      top_nxt   = opnd_r;
      ram_we    = 1'b1;
    end else if (cmd.do_neg) begin
      top_nxt   = neg_val;
      ram_we    = 1'b1;
      ram_waddr = cnt_m1[AW-1:0];
      ram_wdata = neg_val;
    end else if (cmd.do_ret) begin
      count_nxt = '0;
    end else if (cmd.wb) begin
      count_nxt = cnt_m1;
      top_nxt   = res_r;
      ram_we    = 1'b1;
      ram_waddr = cnt_m2[AW-1:0];
      ram_wdata = res_r;
    end
  end

  scs_ram #(
    .WIDTH (DW),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_m2[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (cmd.load_in) opnd_r <= in_operand;
    if (cmd.lat_first) a_r <= ram_rdata;
    if (cmd.exec) begin
      case (cmd.op)
        scs_pkg::OP_MUL: p_r <= (2*DW)'(a_r) * (2*DW)'(top_r);
        scs_pkg::OP_DIV: begin
          dq_r  <= {ua, {FW{1'b0}}};
          rem_r <= '0;
          ub_r  <= ub;
          neg_r <= a_r[DW-1] ^ top_r[DW-1];
          cnt_r <= '0;
        end
        default: res_r <= sum_sat;
      endcase
    end
    if (cmd.div_step) begin
      rem_r <= rem_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      dq_r  <= {dq_r[QW-2:0], rem_ge};
      cnt_r <= cnt_r + scs_pkg::DIV_CNT_W'(1);
    end
    if (cmd.mul_fin) res_r <= mul_sat;
    if (cmd.div_fin) res_r <= div_sat;
    if (cmd.out_load) begin
      ost_r    <= cmd.status;
      ofin_r   <= cmd.fin;
      odepth_r <= scs_pkg::DEPTH_W'(count_r);
      // an empty stack shows zero, except the value just popped by return
      otop_r   <= (cmd.fin || count_r != '0) ? top_r : '0;
    end
  end

  assign sts.count_zero = (count_r == '0);
  assign sts.count_lt2  = (count_r < CW'(2));
  assign sts.count_full = (count_r == CW'(STACK_DEPTH));
  assign sts.top_zero   = (top_r == '0);
  assign sts.div_last   = (cnt_r == scs_pkg::DIV_CNT_W'(QW - 1));

  assign out_status    = ost_r;
  assign out_top_value = otop_r;
  assign out_depth     = odepth_r;
  assign out_finished  = ofin_r;

endmodule

[src/stack_calculator_unit.sv]
// ----------------------------------------------------------------------------
// stack_calculator_unit
// Stack-machine interpreter on signed Q16.16 values with saturating math.
// ----------------------------------------------------------------------------
// One instruction (in_func, in_operand) is taken per transfer on the input
// channel; exactly one result (status, top value, depth, finished) leaves on
// the output channel for each instruction, in order.
// Push, negate, return and failed steps go from decode straight to the
// result; add and sub also pass read, execute and write-back, multiply
// adds a product step and divide adds its quotient steps and a final
// step. The restoring divider resolves one of 48 quotient bits per cycle.
// One instruction is in flight at a time; in_ready is high while the
// sequencer is idle, so no new instruction is taken until the last is done.
// The result sits in an output register: a new instruction is taken while
// it waits. If the receiver stalls and the next result is ready, that
// result is held in the sequencer until the output register frees up.
// Reset empties the stack and drops any pending result; stack ram contents
// need no clearing since only entries written by push are ever read.
// ----------------------------------------------------------------------------
module stack_calculator_unit #(
  parameter int STACK_DEPTH = scs_pkg::STACK_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          in_func,
  input  logic signed [scs_pkg::DATA_W-1:0]   in_operand,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic signed [scs_pkg::DATA_W-1:0]   out_top_value,
  output logic [scs_pkg::DEPTH_W-1:0]         out_depth,
  output logic                                out_finished
);

  scs_pkg::cmd_t    cmd;
  scs_pkg::dp_sts_t sts;

  scs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  scs_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_operand    (in_operand),
    .cmd           (cmd),
    .sts           (sts),
    .out_status    (out_status),
    .out_top_value (out_top_value),
    .out_depth     (out_depth),
    .out_finished  (out_finished)
  );

endmodule

[src/scs_checker.sv]
// ----------------------------------------------------------------------------
// scs_checker
// Port-level checks on the stack calculator results, bound to the top level.
// ----------------------------------------------------------------------------
module scs_checker #(
  parameter int STACK_DEPTH = scs_pkg::STACK_DEPTH_DEF
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [1:0]                          out_status,
  input logic signed [scs_pkg::DATA_W-1:0]   out_top_value,
  input logic [scs_pkg::DEPTH_W-1:0]         out_depth,
  input logic                                out_finished
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_top_value) &&
    $stable(out_status) && $stable(out_depth) && $stable(out_finished))
    else $error("result changed while stalled");

  // a return leaves an empty stack and reports success
  a_fin_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> out_depth == '0 && out_status == scs_pkg::ST_OK)
    else $error("finished result with nonempty stack or error");

  // a full-stack error only happens at capacity
  a_full_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == scs_pkg::ST_FULL |->
    out_depth == scs_pkg::DEPTH_W'(STACK_DEPTH))
    else $error("stack full reported below capacity");

  // an empty stack shows zero unless a value was just returned
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_depth == '0 && !out_finished |-> out_top_value == '0)
    else $error("empty stack shows nonzero top");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind stack_calculator_unit scs_checker #(.STACK_DEPTH(STACK_DEPTH)) u_scs_checker (.*);
